/* sv/prbd_pkg.sv */
package prbd_pkg;

  localparam int unsigned EncABit     = 0;
  localparam int unsigned EncBBit     = 1;
  localparam int unsigned Button0Bit  = 2;
  localparam int unsigned Button1Bit  = 3;
  localparam int unsigned Button2Bit  = 4;
  localparam int unsigned NumButtons  = 3;

  localparam logic [7:0]  TicksReset   = 8'd1;
  localparam logic [15:0] MinHoldReset = 16'd100;
  localparam logic [15:0] LongReset    = 16'd1000;

  localparam logic [5:0] PhIdle     = 6'h00;
  localparam logic [5:0] PhCwLast   = 6'h01;
  localparam logic [5:0] PhCwStart  = 6'h02;
  localparam logic [5:0] PhCwMid    = 6'h03;
  localparam logic [5:0] PhCcwStart = 6'h04;
  localparam logic [5:0] PhCcwLast  = 6'h05;
  localparam logic [5:0] PhCcwMid   = 6'h06;
  localparam logic [5:0] FlagCw     = 6'h10;
  localparam logic [5:0] FlagCcw    = 6'h20;
  localparam logic [5:0] RowMask    = 6'h0F;
  localparam logic [5:0] DirMask    = 6'h30;

  localparam logic signed [1:0] StepNone = 2'sd0;
  localparam logic signed [1:0] StepCw   = -2'sd1;
  localparam logic signed [1:0] StepCcw  = 2'sd1;

  typedef enum logic [1:0] {
    RegTicksPerStep  = 2'd0,
    RegInvertRotation = 2'd1,
    RegMinHoldMs     = 2'd2,
    RegLongPressMs   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  port_byte;
    logic [31:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic signed [1:0] rotary_step;
    logic [2:0]        short_press;
    logic [2:0]        long_press;
  } out_req_t;

  function automatic logic [5:0] phase_next(input logic [5:0] phase, input logic [1:0] ab);
    logic [5:0] row;
    logic [5:0] nxt;
    row = phase & RowMask;
    nxt = PhIdle;
    case (row)
      PhCwLast: begin
        case (ab)
          2'd0:    nxt = PhCwMid;
          2'd1:    nxt = PhIdle;
          2'd2:    nxt = PhCwLast;
          default: nxt = PhIdle | FlagCw;
        endcase
      end
      PhCwStart: begin
        case (ab)
          2'd0:    nxt = PhCwMid;
          2'd1:    nxt = PhCwStart;
          default: nxt = PhIdle;
        endcase
      end
      PhCwMid: begin
        case (ab)
          2'd0:    nxt = PhCwMid;
          2'd1:    nxt = PhCwStart;
          2'd2:    nxt = PhCwLast;
          default: nxt = PhIdle;
        endcase
      end
      PhCcwStart: begin
        case (ab)
          2'd0:    nxt = PhCcwMid;
          2'd2:    nxt = PhCcwStart;
          default: nxt = PhIdle;
        endcase
      end
      PhCcwLast: begin
        case (ab)
          2'd0:    nxt = PhCcwMid;
          2'd1:    nxt = PhCcwLast;
          2'd2:    nxt = PhIdle;
          default: nxt = PhIdle | FlagCcw;
        endcase
      end
      PhCcwMid: begin
        case (ab)
          2'd0:    nxt = PhCcwMid;
          2'd1:    nxt = PhCcwLast;
          2'd2:    nxt = PhCcwStart;
          default: nxt = PhIdle;
        endcase
      end
      default: begin
        // idle row, also taken for phases that cannot occur
        case (ab)
          2'd1:    nxt = PhCwStart;
          2'd2:    nxt = PhCcwStart;
          default: nxt = PhIdle;
        endcase
      end
    endcase
    return nxt;
  endfunction

endpackage

/* sv/panel_rotary_and_button_decoder.sv */
// Decodes one sampled 8-bit panel port per request: encoder A/B on bits 0/1 drive a
// seven-phase quadrature table, and every ticks_per_step detents in one direction give
// a signed step (-1 clockwise, +1 counter-clockwise, negated when invert_rotation is
// set). Three active-low buttons on bits 2..4 latch a press with its timestamp; a
// release after more than min_hold_ms gives a one-request short or long pulse, long
// when the hold exceeded long_press_ms, hold times taken modulo 2^32. Exactly one
// result comes out per request. Each request goes into an input register, is decoded
// into the result register; one request per cycle while the output is not stalled,
// the input register taking one more while a result is stalled. The user writes the
// configuration via cfg_we_i/cfg_idx_i/cfg_data_i only while idle; it is unchecked.
module panel_rotary_and_button_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  prbd_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output prbd_pkg::out_req_t  out_req_o
);
  import prbd_pkg::*;

  logic [7:0]  ticks_q;
  logic        invert_q;
  logic [15:0] min_hold_q;
  logic [15:0] long_q;

  logic        in_valid_q;
  in_req_t     in_q;
  logic        out_valid_q;
  out_req_t    out_q;

  logic [5:0]  phase_q, phase_d;
  logic        going_cw_q, going_cw_d;
  logic [7:0]  count_q, count_d;
  logic [NumButtons-1:0] held_q, held_d;
  logic [31:0] start_q [NumButtons];

  logic        advance;
  logic [1:0]  ab;
  logic [5:0]  dir;
  logic        detent, cw;
  logic        below_limit;
  logic        ticks_le_one;
  logic signed [1:0] raw_step, step;
  logic [NumButtons-1:0] pressed, set_start, shorts, longs;
  logic [31:0] held_time [NumButtons];
  logic [NumButtons-1:0] release_ok, is_long;
  logic [2:0]  btn_pos [NumButtons];

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q    <= TicksReset;
      invert_q   <= 1'b0;
      min_hold_q <= MinHoldReset;
      long_q     <= LongReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegTicksPerStep:   ticks_q    <= cfg_data_i[7:0];
        RegInvertRotation: invert_q   <= cfg_data_i[0];
        RegMinHoldMs:      min_hold_q <= cfg_data_i;
        RegLongPressMs:    long_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // rotary path
  always_comb begin
    ab           = {in_q.port_byte[EncBBit[2:0]], in_q.port_byte[EncABit[2:0]]};
    phase_d      = phase_next(phase_q, ab);
    dir          = phase_d & DirMask;
    detent       = (dir == FlagCw) || (dir == FlagCcw);
    cw           = (dir == FlagCw);
    below_limit  = ({1'b0, count_q} + 9'd1) < {1'b0, ticks_q};
    ticks_le_one = (ticks_q <= 8'd1);
    going_cw_d   = going_cw_q;
    count_d      = count_q;
    raw_step     = StepNone;
    if (detent) begin
      if (going_cw_q == cw) begin
        if (below_limit) begin
          count_d = count_q + 8'd1;
        end else begin
          count_d  = 8'd0;
          raw_step = cw ? StepCw : StepCcw;
        end
      end else begin
        count_d    = 8'd1;
        going_cw_d = cw;
        if (ticks_le_one) raw_step = cw ? StepCw : StepCcw;
      end
    end
    step = invert_q ? -raw_step : raw_step;
  end

  // button path, the three buttons in parallel
  assign btn_pos[0] = Button0Bit[2:0];
  assign btn_pos[1] = Button1Bit[2:0];
  assign btn_pos[2] = Button2Bit[2:0];

  always_comb begin
    held_d = held_q;
    for (int i = 0; i < NumButtons; i++) begin
      pressed[i]    = !in_q.port_byte[btn_pos[i]];
      held_time[i]  = in_q.now_ms - start_q[i];
      release_ok[i] = (held_time[i] > {16'd0, min_hold_q}) && !pressed[i];
      is_long[i]    = held_time[i] > {16'd0, long_q};
      set_start[i]  = !held_q[i] && pressed[i];
      shorts[i]     = held_q[i] && release_ok[i] && !is_long[i];
      longs[i]      = held_q[i] && release_ok[i] && is_long[i];
      if (set_start[i]) held_d[i] = 1'b1;
      if (held_q[i] && release_ok[i]) held_d[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhIdle;
      going_cw_q  <= 1'b1;
      count_q     <= 8'd0;
      held_q      <= '0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        going_cw_q  <= going_cw_d;
        count_q     <= count_d;
        held_q      <= held_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_req_i;
    if (advance) begin
      out_q.rotary_step <= step;
      out_q.short_press <= shorts;
      out_q.long_press  <= longs;
      for (int i = 0; i < NumButtons; i++) begin
        if (set_start[i]) start_q[i] <= in_q.now_ms;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
